[hdl/hcp_pkg.sv]
// Shared constants, stage payload types and the per-level Hilbert step.
`default_nettype none
package hcp_pkg;

   localparam int MAX_ORDER = 8;
   localparam int FRAC_BITS = 8;

   localparam int ORDER_W = 4;
   localparam int SIDE_W  = 12;
   localparam int CELL_W  = MAX_ORDER;
   localparam int IDX_W   = 2 * MAX_ORDER;
   localparam int POS_W   = IDX_W + FRAC_BITS;
   localparam int COORD_W = 20;
   localparam int LVL_W   = $clog2(MAX_ORDER + 1);
   localparam int HALF    = MAX_ORDER / 2;
   // Twice the interpolated cell coordinate with fraction bits.
   localparam int AMP_W   = CELL_W + 2 + FRAC_BITS;
   localparam int PROD_W  = AMP_W + SIDE_W;

   localparam int REQ_DATA_W = ((POS_W + 7) / 8) * 8;
   localparam int RSP_DATA_W = ((2 * COORD_W + 2 * CELL_W + 7) / 8) * 8;

   localparam int CSR_ADDR_W = 1;
   localparam logic [CSR_ADDR_W-1:0] REG_GRID_ORDER  = CSR_ADDR_W'(0);
   localparam logic [CSR_ADDR_W-1:0] REG_SIDE_PIXELS = CSR_ADDR_W'(1);

   localparam logic [ORDER_W-1:0] GRID_ORDER_RESET  = ORDER_W'(3);
   localparam logic [SIDE_W-1:0]  SIDE_PIXELS_RESET = SIDE_W'(480);

   typedef struct packed {
      logic [ORDER_W-1:0]   order;
      logic [FRAC_BITS-1:0] frac;
      logic [IDX_W-1:0]     t0;
      logic [IDX_W-1:0]     t1;
      logic [CELL_W-1:0]    x0;
      logic [CELL_W-1:0]    y0;
      logic [CELL_W-1:0]    x1;
      logic [CELL_W-1:0]    y1;
   } hcp_walk_type;

   typedef struct packed {
      logic [ORDER_W-1:0] order;
      logic [AMP_W-1:0]   ax;
      logic [AMP_W-1:0]   ay;
      logic [CELL_W-1:0]  cx;
      logic [CELL_W-1:0]  cy;
   } hcp_amp_type;

   typedef struct packed {
      logic [ORDER_W-1:0] order;
      logic [PROD_W-1:0]  px;
      logic [PROD_W-1:0]  py;
      logic [CELL_W-1:0]  cx;
      logic [CELL_W-1:0]  cy;
   } hcp_prod_type;

   // One level of the index-to-cell walk. Returns {y, x}.
   function automatic logic [2*CELL_W-1:0] hcp_level(
      input logic [LVL_W-1:0]  lvl,
      input logic [1:0]        digit,
      input logic [CELL_W-1:0] x,
      input logic [CELL_W-1:0] y
   );
      logic [CELL_W-1:0] mask;
      logic [CELL_W-1:0] xn;
      logic [CELL_W-1:0] yn;
      logic              rx;
      logic              ry;
      mask = (CELL_W'(1) << lvl) - CELL_W'(1);
      rx   = digit[1];
      ry   = digit[0] ^ digit[1];
      xn   = x;
      yn   = y;
      if (!ry) begin
         if (rx) begin
            xn = ~x & mask;
            yn = ~y & mask;
         end
         {xn, yn} = {yn, xn};
      end
      xn = xn | (CELL_W'(rx) << lvl);
      yn = yn | (CELL_W'(ry) << lvl);
      return {yn, xn};
   endfunction

endpackage
`default_nettype wire

[hdl/hcp_map.sv]
// Two pipeline stages that map both curve indices to grid cells, half the levels each.
`default_nettype none
module hcp_map (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 in_valid,
   output logic                      in_ready,
   input  wire hcp_pkg::hcp_walk_type in_data,
   output logic                      out_valid,
   input  wire logic                 out_ready,
   output hcp_pkg::hcp_walk_type     out_data
);
   import hcp_pkg::*;

   logic         m1_valid_ff;
   logic         m2_valid_ff;
   hcp_walk_type m1_ff;
   hcp_walk_type m1_in;
   hcp_walk_type m2_ff;
   hcp_walk_type m2_in;
   logic         m1_ready;
   logic         m2_ready;

   assign m2_ready = !m2_valid_ff || out_ready;
   assign m1_ready = !m1_valid_ff || m2_ready;
   assign in_ready = m1_ready;

   // Levels at or above the grid order leave the cell untouched.
   always_comb begin
      m1_in = in_data;
      for (int i = 0; i < HALF; i++) begin
         if (i < int'(in_data.order)) begin
            {m1_in.y0, m1_in.x0} = hcp_level(LVL_W'(i), in_data.t0[2*i +: 2],
                                             m1_in.x0, m1_in.y0);
            {m1_in.y1, m1_in.x1} = hcp_level(LVL_W'(i), in_data.t1[2*i +: 2],
                                             m1_in.x1, m1_in.y1);
         end
      end
   end

   always_comb begin
      m2_in = m1_ff;
      for (int i = HALF; i < MAX_ORDER; i++) begin
         if (i < int'(m1_ff.order)) begin
            {m2_in.y0, m2_in.x0} = hcp_level(LVL_W'(i), m1_ff.t0[2*i +: 2],
                                             m2_in.x0, m2_in.y0);
            {m2_in.y1, m2_in.x1} = hcp_level(LVL_W'(i), m1_ff.t1[2*i +: 2],
                                             m2_in.x1, m2_in.y1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m1_valid_ff <= 1'b0;
         m2_valid_ff <= 1'b0;
      end else begin
         if (m1_ready) begin
            m1_valid_ff <= in_valid;
         end
         if (m2_ready) begin
            m2_valid_ff <= m1_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (m1_ready && in_valid) begin
         m1_ff <= m1_in;
      end
      if (m2_ready && m1_valid_ff) begin
         m2_ff <= m2_in;
      end
   end

   assign out_valid = m2_valid_ff;
   assign out_data  = m2_ff;

endmodule
`default_nettype wire

[hdl/hcp_scale.sv]
// Interpolation, scaling multiply and rounding stages, ending in the output register.
`default_nettype none
module hcp_scale (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic [hcp_pkg::SIDE_W-1:0]  side_pixels,
   input  wire logic                        in_valid,
   output logic                             in_ready,
   input  wire hcp_pkg::hcp_walk_type       in_data,
   output logic                             out_valid,
   input  wire logic                        out_ready,
   output logic [hcp_pkg::COORD_W-1:0]      x_pos,
   output logic [hcp_pkg::COORD_W-1:0]      y_pos,
   output logic [hcp_pkg::CELL_W-1:0]       cell_x,
   output logic [hcp_pkg::CELL_W-1:0]       cell_y
);
   import hcp_pkg::*;

   logic         a_valid_ff;
   logic         p_valid_ff;
   logic         o_valid_ff;
   hcp_amp_type  a_ff;
   hcp_amp_type  a_in;
   hcp_prod_type p_ff;
   hcp_prod_type p_in;
   logic [COORD_W-1:0] x_pos_ff;
   logic [COORD_W-1:0] y_pos_ff;
   logic [COORD_W-1:0] x_pos_in;
   logic [COORD_W-1:0] y_pos_in;
   logic [CELL_W-1:0]  cell_x_ff;
   logic [CELL_W-1:0]  cell_y_ff;
   logic a_ready;
   logic p_ready;
   logic o_ready;

   assign o_ready  = !o_valid_ff || out_ready;
   assign p_ready  = !p_valid_ff || o_ready;
   assign a_ready  = !a_valid_ff || p_ready;
   assign in_ready = a_ready;

   // Twice the cell centre, moved by twice the fraction toward the next cell.
   function automatic logic [AMP_W-1:0] amp(
      input logic [CELL_W-1:0]    c0,
      input logic [CELL_W-1:0]    c1,
      input logic [FRAC_BITS-1:0] f
   );
      logic [AMP_W-1:0] base;
      logic [AMP_W-1:0] two_f;
      base  = AMP_W'({c0, 1'b1}) << FRAC_BITS;
      two_f = AMP_W'({f, 1'b0});
      if (c1 > c0) begin
         return base + two_f;
      end else if (c1 < c0) begin
         return base - two_f;
      end
      return base;
   endfunction

   // Adds half a cell span for round to nearest, then divides by twice the grid side.
   function automatic logic [COORD_W-1:0] round_coord(
      input logic [PROD_W-1:0]  p,
      input logic [ORDER_W-1:0] order
   );
      logic [PROD_W:0]  sum;
      logic [PROD_W:0]  shifted;
      logic [ORDER_W:0] sh;
      sh      = {1'b0, order} + (ORDER_W+1)'(1);
      sum     = (PROD_W+1)'(p) + ((PROD_W+1)'(1) << order);
      shifted = sum >> sh;
      return shifted[COORD_W-1:0];
   endfunction

   always_comb begin
      a_in.order = in_data.order;
      a_in.ax    = amp(in_data.x0, in_data.x1, in_data.frac);
      a_in.ay    = amp(in_data.y0, in_data.y1, in_data.frac);
      a_in.cx    = in_data.x0;
      a_in.cy    = in_data.y0;
   end

   always_comb begin
      p_in.order = a_ff.order;
      p_in.px    = PROD_W'(a_ff.ax) * PROD_W'(side_pixels);
      p_in.py    = PROD_W'(a_ff.ay) * PROD_W'(side_pixels);
      p_in.cx    = a_ff.cx;
      p_in.cy    = a_ff.cy;
   end

   assign x_pos_in = round_coord(p_ff.px, p_ff.order);
   assign y_pos_in = round_coord(p_ff.py, p_ff.order);

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         p_valid_ff <= 1'b0;
         o_valid_ff <= 1'b0;
      end else begin
         if (a_ready) begin
            a_valid_ff <= in_valid;
         end
         if (p_ready) begin
            p_valid_ff <= a_valid_ff;
         end
         if (o_ready) begin
            o_valid_ff <= p_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (a_ready && in_valid) begin
         a_ff <= a_in;
      end
      if (p_ready && a_valid_ff) begin
         p_ff <= p_in;
      end
      if (o_ready && p_valid_ff) begin
         x_pos_ff  <= x_pos_in;
         y_pos_ff  <= y_pos_in;
         cell_x_ff <= p_ff.cx;
         cell_y_ff <= p_ff.cy;
      end
   end

   assign out_valid = o_valid_ff;
   assign x_pos     = x_pos_ff;
   assign y_pos     = y_pos_ff;
   assign cell_x    = cell_x_ff;
   assign cell_y    = cell_y_ff;

endmodule
`default_nettype wire

[hdl/hilbert_curve_position.sv]
// Hilbert curve position to screen coordinates: top level with clamp stage and registers.
//
// Usage: each transfer on the req_ stream carries one curve position (unsigned,
// eight fraction bits). For each one, the rsp_ stream carries exactly one result
// in order: the interpolated screen x and y (eight fraction bits) and the grid
// cell at the integer position. grid_order and side_pixels are written through
// the csr_ port (index 0 and 1) while no item is in flight.
// The pipeline has six register stages: clamp, two walk stages of four levels
// each, interpolation, multiply and rounding into the output register. A result
// is valid on rsp_tvalid once its request has passed through every stage. One item
// is taken every cycle while the output is not stalled.
// When the receiver holds rsp_tready low, results stay in their stages and
// req_tready drops only once every stage is full; nothing is lost or repeated.
// Reset empties the pipeline and sets grid_order to 3 and side_pixels to 480.
`default_nettype none
module hilbert_curve_position (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   // [23:0] position
   input  wire logic [hcp_pkg::REQ_DATA_W-1:0]  req_tdata,
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   // [19:0] x_pos, [39:20] y_pos, [47:40] cell_x, [55:48] cell_y
   output logic [hcp_pkg::RSP_DATA_W-1:0]       rsp_tdata,
   input  wire logic                            csr_we,
   input  wire logic [hcp_pkg::CSR_ADDR_W-1:0]  csr_addr,
   input  wire logic [hcp_pkg::SIDE_W-1:0]      csr_wdata
);
   import hcp_pkg::*;

   logic [ORDER_W-1:0] grid_order_ff;
   logic [SIDE_W-1:0]  side_pixels_ff;

   logic               s0_valid_ff;
   hcp_walk_type       s0_ff;
   hcp_walk_type       s0_in;
   logic               s0_ready;

   logic [ORDER_W-1:0] order_sat;
   logic [IDX_W:0]     cells;
   logic [IDX_W-1:0]   last_idx;
   logic [POS_W-1:0]   limit;
   logic [POS_W-1:0]   pos;
   logic [POS_W-1:0]   pos_cl;
   logic [IDX_W-1:0]   d;

   logic               map_in_ready;
   logic               map_out_valid;
   hcp_walk_type       map_out;
   logic               scale_in_ready;
   logic [COORD_W-1:0] x_pos;
   logic [COORD_W-1:0] y_pos;
   logic [CELL_W-1:0]  cell_x;
   logic [CELL_W-1:0]  cell_y;

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_order_ff  <= GRID_ORDER_RESET;
         side_pixels_ff <= SIDE_PIXELS_RESET;
      end else if (csr_we) begin
         case (csr_addr)
            REG_GRID_ORDER: begin
               grid_order_ff <= csr_wdata[ORDER_W-1:0];
            end
            REG_SIDE_PIXELS: begin
               side_pixels_ff <= csr_wdata;
            end
            default: begin
            end
         endcase
      end
   end

   // Clamp the position to the last cell and form the current and next index.
   always_comb begin
      order_sat = (grid_order_ff > ORDER_W'(MAX_ORDER)) ? ORDER_W'(MAX_ORDER) : grid_order_ff;
      cells     = (IDX_W+1)'(1) << {order_sat, 1'b0};
      last_idx  = IDX_W'(cells - (IDX_W+1)'(1));
      limit     = POS_W'(last_idx) << FRAC_BITS;
      pos       = req_tdata[POS_W-1:0];
      pos_cl    = (pos > limit) ? limit : pos;
      d         = pos_cl[POS_W-1 -: IDX_W];

      s0_in.order = order_sat;
      s0_in.frac  = pos_cl[FRAC_BITS-1:0];
      s0_in.t0    = d;
      s0_in.t1    = (d == last_idx) ? d : d + IDX_W'(1);
      s0_in.x0    = '0;
      s0_in.y0    = '0;
      s0_in.x1    = '0;
      s0_in.y1    = '0;
   end

   assign s0_ready   = !s0_valid_ff || map_in_ready;
   assign req_tready = s0_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (s0_ready) begin
         s0_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (s0_ready && req_tvalid) begin
         s0_ff <= s0_in;
      end
   end

   hcp_map u_map (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s0_valid_ff),
      .in_ready  (map_in_ready),
      .in_data   (s0_ff),
      .out_valid (map_out_valid),
      .out_ready (scale_in_ready),
      .out_data  (map_out)
   );

   hcp_scale u_scale (
      .clock       (clock),
      .reset       (reset),
      .side_pixels (side_pixels_ff),
      .in_valid    (map_out_valid),
      .in_ready    (scale_in_ready),
      .in_data     (map_out),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .x_pos       (x_pos),
      .y_pos       (y_pos),
      .cell_x      (cell_x),
      .cell_y      (cell_y)
   );

   assign rsp_tdata = RSP_DATA_W'({cell_y, cell_x, y_pos, x_pos});

   // A clamp-stage item that cannot move on is held unchanged.
   a_s0_hold: assert property (@(posedge clock) disable iff (reset)
      s0_valid_ff && !map_in_ready |=> s0_valid_ff && $stable(s0_ff))
      else $error("clamp stage item changed while stalled");

   // The input stalls only when the clamp stage is occupied.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> s0_valid_ff)
      else $error("input stalled with an empty clamp stage");

   // The next index is the current one or its successor, and the order is saturated.
   a_next_idx: assert property (@(posedge clock) disable iff (reset)
      s0_valid_ff |-> (s0_ff.t1 == s0_ff.t0 || s0_ff.t1 == s0_ff.t0 + IDX_W'(1))
                      && s0_ff.order <= ORDER_W'(MAX_ORDER))
      else $error("bad index pair or order in clamp stage");

endmodule
`default_nettype wire
